// ----- hw/rtl/lmfe_pkg.sv -----
// Package for the LIN master frame engine: payload structs, the queue entry
// that links the front and back parts, symbol and status codes, PID and checksum helpers.
// No dependencies.
package lmfe_pkg;

    // Largest data length a receive uses; longer requests are clamped to it.
    localparam int unsigned MAX_DATA_BYTES = 8;

    // Depth of the queue between the front and back parts.
    localparam int unsigned CMD_FIFO_DEPTH = 4;
    localparam int unsigned CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);
    localparam int unsigned CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

    // Request types.
    localparam logic [1:0] REQ_SEND = 2'd0;
    localparam logic [1:0] REQ_RECV = 2'd1;
    localparam logic [1:0] REQ_LINE = 2'd2;
    localparam logic [1:0] REQ_TICK = 2'd3;

    // Result symbol kinds.
    localparam logic [1:0] KIND_BREAK   = 2'd0;
    localparam logic [1:0] KIND_TX_BYTE = 2'd1;
    localparam logic [1:0] KIND_RX_DATA = 2'd2;
    localparam logic [1:0] KIND_STATUS  = 2'd3;

    // Frame status codes.
    localparam logic [2:0] ST_NONE      = 3'd0;
    localparam logic [2:0] ST_OK        = 3'd1;
    localparam logic [2:0] ST_CKSUM_ERR = 3'd2;
    localparam logic [2:0] ST_TIMEOUT   = 3'd3;
    localparam logic [2:0] ST_REFUSED   = 3'd4;

    localparam logic [7:0] SYNC_BYTE       = 8'h55;
    localparam logic [7:0] TIMEOUT_DEFAULT = 8'hFF;
    localparam logic [7:0] TICK_MAX        = 8'hFF;

    // Bit positions in the symbol mask, in emission order.
    localparam int unsigned SYM_BREAK  = 0;
    localparam int unsigned SYM_SYNC   = 1;
    localparam int unsigned SYM_PID    = 2;
    localparam int unsigned SYM_BYTE   = 3;
    localparam int unsigned SYM_CKSUM  = 4;
    localparam int unsigned SYM_STATUS = 5;
    localparam int unsigned SYM_COUNT  = 6;

    typedef struct packed {
        logic [1:0] req_type;
        logic [5:0] frame_id;
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic [3:0] receive_length;
    } t_in_req;

    typedef struct packed {
        logic [1:0] symbol_kind;
        logic [7:0] symbol_byte;
        logic [2:0] frame_status;
        logic       last_of_run;
    } t_out_res;

    // One queue entry: which symbols a request produces and their values.
    typedef struct packed {
        logic [SYM_COUNT-1:0] sym_mask;
        logic [7:0]           pid;
        logic [1:0]           byte_kind;
        logic [7:0]           byte_val;
        logic [7:0]           cksum;
        logic [2:0]           status;
    } t_cmd;

    // Protected identifier: two parity bits above the six-bit id.
    function automatic logic [7:0] make_pid(input logic [5:0] id);
        logic p0;
        logic p1;
        p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
        p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
        return {p1, p0, id};
    endfunction

    // Eight-bit add with end-around carry.
    function automatic logic [7:0] add_carry(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8] ? (s[7:0] + 8'd1) : s[7:0];
    endfunction

endpackage

// ----- hw/rtl/lin_master_frame_engine_top.sv -----
// Top level of the LIN master frame engine: front part, run queue and back part.
// Depends on lmfe_pkg, lmfe_front, lmfe_queue and lmfe_back.
//
// Usage: requests enter through a queue-style port. A request is taken at a
// rising edge where i_push is high and o_full is low. Results leave through a
// queue-style port: while o_empty is low the oldest result is on o_pop_data,
// and it is removed at an edge where i_pop is high.
// Each request yields zero to five results (break, sync, PID, data byte,
// checksum, or a status), the last of them flagged with last_of_run.
// The front part updates the frame state in the cycle a request is taken, so
// a request may follow in every cycle while the queue has room. The back part
// emits one result per cycle while its output is not held. A request with
// results yields one to five of them (a full send frame byte with header and
// checksum yields five). With the back part idle, the first result of a
// request reaches o_pop_data at the clock edge after the one that takes the
// request.
// When the receiver holds off popping, results wait in the output register,
// the back part stops, and the four-entry run queue absorbs further requests
// before o_full rises. The timeout register is written through i_cfg_wr_en /
// i_cfg_wr_data. Synchronous reset clears the control state, empties the
// queue and sets the timeout to 255 ticks.
module lin_master_frame_engine_top
    import lmfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_push,
    output logic       o_full,
    input  t_in_req    i_push_data,
    input  logic       i_pop,
    output logic       o_empty,
    output t_out_res   o_pop_data
);

    logic accept;
    logic cmd_push;
    t_cmd cmd_in;
    logic q_empty;
    t_cmd q_head;
    logic head_pop;

    // A request is taken whenever the run queue has room.
    assign accept = i_push && !o_full;

    lmfe_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_req         (i_push_data),
        .o_cmd_push    (cmd_push),
        .o_cmd         (cmd_in)
    );

    // Requests that produce results are queued as a symbol run.
    lmfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .i_pop   (head_pop),
        .o_full  (o_full),
        .o_empty (q_empty),
        .o_data  (q_head)
    );

    // The back part walks each run and drives the result register.
    lmfe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (!q_empty),
        .i_head       (q_head),
        .o_head_pop   (head_pop),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_res        (o_pop_data)
    );

endmodule

// ----- hw/rtl/lmfe_front.sv -----
// Front part of the LIN master frame engine: holds the frame state, takes
// requests, updates the sums and counters and builds queue entries. Uses lmfe_pkg.
module lmfe_front
    import lmfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_accept,
    input  t_in_req    i_req,
    output logic       o_cmd_push,
    output t_cmd       o_cmd
);

    logic [7:0] r_timeout, n_timeout;
    logic [7:0] r_send_sum, n_send_sum;
    logic       r_busy, n_busy;
    logic [1:0] r_echo, n_echo;
    logic [3:0] r_count, n_count;
    logic [3:0] r_exp_len, n_exp_len;
    logic [7:0] r_recv_sum, n_recv_sum;
    logic [7:0] r_tick, n_tick;

    logic [7:0] pid;
    logic [7:0] send_base;
    logic [7:0] send_next;
    logic [7:0] tick_inc;
    logic [7:0] limit;
    t_cmd       cmd;

    always_comb begin
        pid       = make_pid(i_req.frame_id);
        send_base = i_req.first_byte ? pid : r_send_sum;
        send_next = add_carry(send_base, i_req.data_byte);
        tick_inc  = (r_tick != TICK_MAX) ? (r_tick + 8'd1) : r_tick;
        limit     = (r_timeout == 8'd0) ? 8'd1 : r_timeout;

        n_timeout  = i_cfg_wr_en ? i_cfg_wr_data : r_timeout;
        n_send_sum = r_send_sum;
        n_busy     = r_busy;
        n_echo     = r_echo;
        n_count    = r_count;
        n_exp_len  = r_exp_len;
        n_recv_sum = r_recv_sum;
        n_tick     = r_tick;

        cmd           = '0;
        cmd.pid       = pid;
        cmd.byte_kind = KIND_TX_BYTE;
        cmd.byte_val  = i_req.data_byte;
        cmd.cksum     = ~send_next;

        case (i_req.req_type)
            REQ_SEND: begin
                cmd.sym_mask[SYM_BREAK] = i_req.first_byte;
                cmd.sym_mask[SYM_SYNC]  = i_req.first_byte;
                cmd.sym_mask[SYM_PID]   = i_req.first_byte;
                cmd.sym_mask[SYM_BYTE]  = 1'b1;
                cmd.sym_mask[SYM_CKSUM] = i_req.last_byte;
                n_send_sum              = send_next;
            end
            REQ_RECV: begin
                if (r_busy) begin
                    cmd.sym_mask[SYM_STATUS] = 1'b1;
                    cmd.status               = ST_REFUSED;
                end else begin
                    cmd.sym_mask[SYM_BREAK] = 1'b1;
                    cmd.sym_mask[SYM_SYNC]  = 1'b1;
                    cmd.sym_mask[SYM_PID]   = 1'b1;
                    n_busy     = 1'b1;
                    n_echo     = 2'd2;
                    n_count    = 4'd0;
                    n_exp_len  = (i_req.receive_length > 4'(MAX_DATA_BYTES))
                               ? 4'(MAX_DATA_BYTES) : i_req.receive_length;
                    n_recv_sum = pid;
                    n_tick     = 8'd0;
                end
            end
            REQ_LINE: begin
                if (r_busy) begin
                    if (r_echo != 2'd0) begin
                        n_echo = r_echo - 2'd1;
                    end else if (r_count < r_exp_len) begin
                        cmd.sym_mask[SYM_BYTE] = 1'b1;
                        cmd.byte_kind          = KIND_RX_DATA;
                        n_recv_sum = add_carry(r_recv_sum, i_req.data_byte);
                        n_count    = r_count + 4'd1;
                    end else begin
                        cmd.sym_mask[SYM_STATUS] = 1'b1;
                        cmd.status = (~r_recv_sum == i_req.data_byte) ? ST_OK : ST_CKSUM_ERR;
                        n_busy     = 1'b0;
                    end
                end
            end
            REQ_TICK: begin
                if (r_busy) begin
                    n_tick = tick_inc;
                    if (tick_inc >= limit) begin
                        cmd.sym_mask[SYM_STATUS] = 1'b1;
                        cmd.status               = ST_TIMEOUT;
                        n_busy                   = 1'b0;
                    end
                end
            end
            default: begin
                cmd.sym_mask = '0;
            end
        endcase
    end

    assign o_cmd      = cmd;
    assign o_cmd_push = i_accept && (cmd.sym_mask != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= TIMEOUT_DEFAULT;
            r_send_sum <= 8'd0;
            r_busy     <= 1'b0;
            r_echo     <= 2'd0;
            r_count    <= 4'd0;
            r_exp_len  <= 4'd0;
            r_recv_sum <= 8'd0;
            r_tick     <= 8'd0;
        end else begin
            r_timeout <= n_timeout;
            if (i_accept) begin
                r_send_sum <= n_send_sum;
                r_busy     <= n_busy;
                r_echo     <= n_echo;
                r_count    <= n_count;
                r_exp_len  <= n_exp_len;
                r_recv_sum <= n_recv_sum;
                r_tick     <= n_tick;
            end
        end
    end

endmodule

// ----- hw/rtl/lmfe_queue.sv -----
// Short queue of pending symbol runs between the front and back parts.
// Uses lmfe_pkg for the entry type and depth.
module lmfe_queue
    import lmfe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_data
);

    t_cmd                 r_mem [CMD_FIFO_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr;
    logic [CMD_PTR_W-1:0] r_rd_ptr;
    logic [CMD_CNT_W-1:0] r_count;

    assign o_full  = (r_count == CMD_CNT_W'(CMD_FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + CMD_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + CMD_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CMD_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CMD_CNT_W'(1);
            end
        end
    end

endmodule

// ----- hw/rtl/lmfe_back.sv -----
// Back part of the LIN master frame engine: expands queue entries into line
// symbols, one per unstalled cycle, into the result register. Uses lmfe_pkg.
module lmfe_back
    import lmfe_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_head_valid,
    input  t_cmd     i_head,
    output logic     o_head_pop,
    input  logic     i_pop,
    output logic     o_empty,
    output t_out_res o_res
);

    logic [SYM_COUNT-1:0] r_mask;
    t_cmd                 r_cmd;
    logic                 r_out_valid;
    t_out_res             r_out;

    logic                 use_head;
    logic [SYM_COUNT-1:0] cur_mask;
    t_cmd                 cur_cmd;
    logic [SYM_COUNT-1:0] sel;
    logic [SYM_COUNT-1:0] rem;
    logic                 out_ready;
    logic                 emit;
    t_out_res             res;

    always_comb begin
        use_head  = (r_mask == '0);
        cur_mask  = use_head ? (i_head_valid ? i_head.sym_mask : '0) : r_mask;
        cur_cmd   = use_head ? i_head : r_cmd;
        // Lowest pending symbol goes out first.
        sel       = cur_mask & (~cur_mask + SYM_COUNT'(1));
        rem       = cur_mask & ~sel;
        out_ready = !r_out_valid || i_pop;
        emit      = out_ready && (cur_mask != '0);

        res              = '0;
        res.last_of_run  = (rem == '0);
        if (sel[SYM_BREAK]) begin
            res.symbol_kind = KIND_BREAK;
        end else if (sel[SYM_SYNC]) begin
            res.symbol_kind = KIND_TX_BYTE;
            res.symbol_byte = SYNC_BYTE;
        end else if (sel[SYM_PID]) begin
            res.symbol_kind = KIND_TX_BYTE;
            res.symbol_byte = cur_cmd.pid;
        end else if (sel[SYM_BYTE]) begin
            res.symbol_kind = cur_cmd.byte_kind;
            res.symbol_byte = cur_cmd.byte_val;
        end else if (sel[SYM_CKSUM]) begin
            res.symbol_kind = KIND_TX_BYTE;
            res.symbol_byte = cur_cmd.cksum;
        end else begin
            res.symbol_kind  = KIND_STATUS;
            res.frame_status = cur_cmd.status;
        end
    end

    assign o_head_pop = emit && use_head;
    assign o_empty    = !r_out_valid;
    assign o_res      = r_out;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= res;
            if (use_head) begin
                r_cmd <= i_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_mask <= rem;
            end
            if (out_ready) begin
                r_out_valid <= emit;
            end
        end
    end

endmodule
